/* rtl/prq_pkg.sv */
// prq_pkg: shared types and constants for the priority ready queue scheduler
// no dependencies
`timescale 1ns / 1ps
package prq_pkg;
   localparam int LEVELS = 8;
   localparam int TASKS = 16;
   localparam int LVL_W = $clog2(LEVELS);
   localparam int TASK_W = $clog2(TASKS);

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0, FUNC_REMOVE = 3'd1, FUNC_TICK = 3'd2,
      FUNC_LOCK = 3'd3, FUNC_UNLOCK = 3'd4
   } func_type;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_DUP_ADD = 2'd1;
   localparam logic [1:0] STATUS_NOT_QUEUED = 2'd2;

   localparam logic CSR_IDLE_TASK = 1'b0;
   localparam logic CSR_RUNNING = 1'b1;

   // per-level queue view offered by each level cell
   typedef struct packed {
      logic                nonempty;
      logic [TASK_W-1:0]   head;
      logic [TASK_W-1:0]   tail;
   } level_view_type;

   // update command broadcast to level cells
   typedef struct packed {
      logic                set_head;
      logic [TASK_W-1:0]   head;
      logic                set_tail;
      logic [TASK_W-1:0]   tail;
      logic                set_nonempty;
      logic                nonempty;
   } level_upd_type;

   // highest-priority candidate passed down the cell chain
   typedef struct packed {
      logic                found;
      logic [TASK_W-1:0]   task_num;
   } pick_type;
endpackage

/* rtl/prq_level_cell.sv */
// prq_level_cell: one priority level, holds head, tail and non-empty flag
// depends on prq_pkg; cells are chained from the highest level down for selection
`timescale 1ns / 1ps
module prq_level_cell import prq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           upd_en,
   input  level_upd_type  upd,
   input  pick_type       pick_in,
   output pick_type       pick_out,
   output level_view_type view
);
   logic              nonempty_ff, nonempty_in;
   logic [TASK_W-1:0] head_ff, head_in, tail_ff, tail_in;

   // next state of this level
   always_comb begin
      nonempty_in = nonempty_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      if (upd_en) begin
         if (upd.set_head) head_in = upd.head;
         if (upd.set_tail) tail_in = upd.tail;
         if (upd.set_nonempty) nonempty_in = upd.nonempty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= 1'b0;
      end else begin
         nonempty_ff <= nonempty_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign view = '{nonempty: nonempty_ff, head: head_ff, tail: tail_ff};

   // pass a higher level's pick through, else offer this head
   always_comb begin
      if (pick_in.found) begin
         pick_out = pick_in;
      end else begin
         pick_out.found = nonempty_ff;
         pick_out.task_num = head_ff;
      end
   end
endmodule

/* rtl/priority_ready_queue_scheduler.sv */
// priority_ready_queue_scheduler: top level, task link table, command decode, result register
// depends on prq_pkg and prq_level_cell
`timescale 1ns / 1ps
// Usage:
//  req_* carries one command beat (add, remove, tick, lock, unlock) with
//  req_valid/req_stall. rsp_* returns one result beat per command: the head
//  of the highest non-empty level (or the idle task), yield flag, lock depth
//  and status. Each command is applied by the link table and the row of level
//  cells when it is accepted; the result is selected through the level cell
//  chain from the highest level down in the following cycle and held in the
//  output register. One command is in flight at a time and req_stall drops
//  only in the cycle after the rsp beat is taken, so each command passes
//  through update, select, then hand-off of the result register before the
//  next is accepted. A stalled rsp beat holds its payload; req_stall stays
//  high until it is taken. Reset empties all levels, clears lock depth and
//  the CSRs (idle task 0, scheduler stopped). csr_* is an APB-style
//  write/read port.
module priority_ready_queue_scheduler import prq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [3:0]        req_task_id,
   input  logic [2:0]        req_priority_req,
   input  logic [3:0]        req_current_task,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_next_task,
   output logic              rsp_next_is_idle,
   output logic              rsp_yield_request,
   output logic [7:0]        rsp_lock_depth,
   output logic [1:0]        rsp_status,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [3:0]        idle_task_ff;
   logic              running_ff;
   logic [7:0]        depth_ff, depth_in;
   logic              busy_ff, sel_ff, rvalid_ff;
   logic              yield_ff, yield_in;
   logic [1:0]        status_ff, status_in;
   logic [3:0]        nt_ff;
   logic              idle_ff;

   logic [TASK_W-1:0] nxt_ff [TASKS];
   logic [TASK_W-1:0] prv_ff [TASKS];
   logic [LVL_W-1:0]  lvl_ff [TASKS];
   logic [TASKS-1:0]  nval_ff, queued_ff;

   level_view_type    view [LEVELS];
   level_upd_type     upd [LEVELS];
   logic [LEVELS-1:0] upd_en;
   pick_type          chain [LEVELS+1];

   logic              accept, csr_wr;

   assign accept = req_valid && !req_stall;
   assign req_stall = busy_ff;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   // level cells, highest level first in the chain
   assign chain[0] = '{found: 1'b0, task_num: '0};
   for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
      prq_level_cell u_cell (
         .clock(clock), .reset(reset),
         .upd_en(upd_en[g]), .upd(upd[g]),
         .pick_in(chain[LEVELS-1-g]), .pick_out(chain[LEVELS-g]),
         .view(view[g])
      );
   end

   // command decode: link table and level updates
   logic [TASK_W-1:0] t, cur, ph, pt;
   logic [LVL_W-1:0]  lv, cl;
   logic              do_add, do_rem, do_tick;
   logic [TASKS-1:0]  nval_n, queued_n;
   logic [TASK_W-1:0] nxt_n [TASKS];
   logic [TASK_W-1:0] prv_n [TASKS];
   logic [LVL_W-1:0]  lvl_n [TASKS];
   logic              hn;
   logic [TASK_W-1:0] nx, pv;

   always_comb begin
      t = req_task_id[TASK_W-1:0];
      cur = req_current_task[TASK_W-1:0];
      cl = lvl_ff[cur];
      status_in = STATUS_OK;
      yield_in = 1'b0;
      depth_in = depth_ff;
      do_add = 1'b0;
      do_rem = 1'b0;
      do_tick = 1'b0;
      nval_n = nval_ff;
      queued_n = queued_ff;
      nxt_n = nxt_ff;
      prv_n = prv_ff;
      lvl_n = lvl_ff;
      upd_en = '0;
      for (int i = 0; i < LEVELS; i++) upd[i] = '0;
      lv = req_priority_req[LVL_W-1:0];
      hn = 1'b0; nx = '0; pv = '0; ph = '0; pt = '0;
      case (func_type'(req_func))
         FUNC_ADD: begin
            if (queued_ff[t]) status_in = STATUS_DUP_ADD;
            else do_add = 1'b1;
         end
         FUNC_REMOVE: begin
            if (!queued_ff[t]) status_in = STATUS_NOT_QUEUED;
            else do_rem = 1'b1;
         end
         FUNC_TICK: begin
            if (running_ff && depth_ff == 8'd0 && req_current_task != idle_task_ff
                && queued_ff[cur] && view[cl].nonempty && nval_ff[view[cl].head]) begin
               do_tick = 1'b1;
               yield_in = 1'b1;
            end
         end
         FUNC_LOCK: if (depth_ff != 8'hFF) depth_in = depth_ff + 8'd1;
         FUNC_UNLOCK: if (depth_ff != 8'd0) depth_in = depth_ff - 8'd1;
         default: ;
      endcase
      if (do_rem || do_tick) begin
         if (do_tick) t = cur;
         lv = lvl_ff[t];
         nx = nxt_ff[t];
         hn = nval_ff[t];
         ph = view[lv].head;
         pt = view[lv].tail;
         upd_en[lv] = 1'b1;
         if (ph == t) begin
            if (hn) begin upd[lv].set_head = 1'b1; upd[lv].head = nx; ph = nx; end
            else begin upd[lv].set_nonempty = 1'b1; upd[lv].nonempty = 1'b0; end
         end else begin
            pv = prv_ff[t];
            nxt_n[pv] = nx;
            nval_n[pv] = hn;
            if (hn) prv_n[nx] = pv;
            else begin upd[lv].set_tail = 1'b1; upd[lv].tail = pv; pt = pv; end
         end
         nval_n[t] = 1'b0;
         queued_n[t] = 1'b0;
      end
      if (do_add || do_tick) begin
         // for tick the level is still non-empty after unlink (two or more tasks)
         lvl_n[t] = lv;
         nval_n[t] = 1'b0;
         upd_en[lv] = 1'b1;
         if (do_tick || view[lv].nonempty) begin
            if (!do_tick) pt = view[lv].tail;
            nxt_n[pt] = t;
            nval_n[pt] = 1'b1;
            prv_n[t] = pt;
         end else begin
            upd[lv].set_head = 1'b1; upd[lv].head = t;
            upd[lv].set_nonempty = 1'b1; upd[lv].nonempty = 1'b1;
         end
         upd[lv].set_tail = 1'b1;
         upd[lv].tail = t;
         queued_n[t] = 1'b1;
      end
      if (!accept) upd_en = '0;
   end

   // link table, control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_task_ff <= 4'd0;
         running_ff <= 1'b0;
         depth_ff <= 8'd0;
         busy_ff <= 1'b0;
         sel_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         nval_ff <= '0;
         queued_ff <= '0;
      end else begin
         if (csr_wr && csr_paddr[2] == CSR_IDLE_TASK && csr_paddr[1:0] == 2'd0)
            idle_task_ff <= csr_pwdata[3:0];
         if (csr_wr && csr_paddr[2] == CSR_RUNNING && csr_paddr[1:0] == 2'd0)
            running_ff <= csr_pwdata[0];
         if (accept) begin
            depth_ff <= depth_in;
            nval_ff <= nval_n;
            queued_ff <= queued_n;
            busy_ff <= 1'b1;
         end else if (rvalid_ff && !rsp_stall) begin
            busy_ff <= 1'b0;
         end
         sel_ff <= accept;
         if (sel_ff) rvalid_ff <= 1'b1;
         else if (!rsp_stall) rvalid_ff <= 1'b0;
      end
      if (accept) begin
         nxt_ff <= nxt_n;
         prv_ff <= prv_n;
         lvl_ff <= lvl_n;
         yield_ff <= yield_in;
         status_ff <= status_in;
      end
      if (sel_ff) begin
         nt_ff <= chain[LEVELS].found ? 4'(chain[LEVELS].task_num) : idle_task_ff;
         idle_ff <= !chain[LEVELS].found;
      end
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_next_task = nt_ff;
   assign rsp_next_is_idle = idle_ff;
   assign rsp_yield_request = yield_ff;
   assign rsp_lock_depth = depth_ff;
   assign rsp_status = status_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == CSR_IDLE_TASK) csr_prdata[3:0] = idle_task_ff;
         else csr_prdata[0] = running_ff;
      end
   end

   // a result is only ever pending while a command is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff) else $error("result without command");
   // no new command while a result waits
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !accept) else $error("accept during pending result");
   // a yield always leaves the rotated task queued
   a_yield: assert property (@(posedge clock) disable iff (reset)
      (accept && yield_in) |=> queued_ff[$past(cur)]) else $error("yield lost task");
endmodule
